@@ rtl/ipv6ap_pkg.sv @@
// Shared types, constants and helper functions for the IPv6 address parser.
// No dependencies; every other file of the block imports this package.
package ipv6ap_pkg;

    localparam int CHAR_W          = 8;
    localparam int PIECE_W         = 16;
    localparam int PIECE_COUNT     = 8;
    localparam int PSEL_W          = $clog2(PIECE_COUNT);
    localparam int IDX_W           = PSEL_W + 1;
    localparam int HALF_W          = 64;
    localparam int HEX_DIGITS      = 4;
    localparam int HCNT_W          = 3;
    localparam int DCNT_W          = 3;
    localparam int DOT_W           = 9;
    localparam int DOT_GROUPS      = 4;
    localparam int DOT_MAX         = 255;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DOT_W-1:0]  DOT_EMPTY = 9'h100;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

    typedef logic [PIECE_W-1:0] t_piece;

    // One finished address handed from the parser to the expansion stage.
    typedef struct packed {
        logic                          ok;
        logic                          compress_seen;
        logic [IDX_W-1:0]              piece_index;
        logic [IDX_W-1:0]              compress_pos;
        t_piece [PIECE_COUNT-1:0]      pieces;
    } t_job;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    typedef struct packed {
        logic             ok;
        logic [DOT_W-1:0] acc;
    } t_dot;

    function automatic t_hex hex_val(input logic [CHAR_W-1:0] c);
        t_hex r;
        r = '0;
        if (c inside {[CH_0:CH_9]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_0);
        end else if (c inside {[CH_LA:CH_LF]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_UA:CH_UF]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_UA + 8'd10);
        end
        return r;
    endfunction

    // One decimal digit into an IPv4 number: no leading zero, at most 255.
    function automatic t_dot dot_step(input logic [DOT_W-1:0] acc, input logic [3:0] d);
        logic [11:0] v;
        t_dot        r;
        if (acc == DOT_EMPTY) begin
            v = {8'd0, d};
        end else begin
            v = {3'd0, acc} * 12'd10 + {8'd0, d};
        end
        r.ok  = (acc != '0) && (v <= 12'(DOT_MAX));
        r.acc = v[DOT_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/ipv6ap_ifs.sv @@
// Valid/ready channel interfaces for the character input and the result output.
// Depends on ipv6ap_pkg for field widths.
interface ipv6ap_in_if;
    import ipv6ap_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;
    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface ipv6ap_out_if;
    import ipv6ap_pkg::*;
    logic              valid;
    logic              ready;
    logic              parse_ok;
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    modport source (output valid, output parse_ok, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input parse_ok, input addr_high, input addr_low,
                    output ready);
endinterface

@@ rtl/ipv6ap_front.sv @@
// Character parser: consumes one byte per word and tracks hex pieces, the '::'
// position and the dotted IPv4 tail; pushes one job per address. Uses ipv6ap_pkg.
module ipv6ap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipv6ap_in_if.sink         i_in,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output ipv6ap_pkg::t_job  o_push_job
);
    import ipv6ap_pkg::*;

    localparam logic [2:0] PH_START       = 3'd0;
    localparam logic [2:0] PH_LEAD        = 3'd1;
    localparam logic [2:0] PH_PIECE       = 3'd2;
    localparam logic [2:0] PH_HEX         = 3'd3;
    localparam logic [2:0] PH_AFTER_COLON = 3'd4;
    localparam logic [2:0] PH_DOTTED      = 3'd5;
    localparam logic [2:0] PH_DONE        = 3'd6;

    typedef struct packed {
        t_piece [PIECE_COUNT-1:0] pieces;
        logic [IDX_W-1:0]         pi;
        logic [DCNT_W-1:0]        cnt;
        logic [7:0]               hi;
    } t_close;

    // Close one IPv4 number; every second number completes a piece.
    function automatic t_close dot_close(input t_close s, input logic [DOT_W-1:0] acc);
        t_close r;
        r     = s;
        r.cnt = s.cnt + 1'b1;
        if (r.cnt[0]) begin
            r.hi = acc[7:0];
        end else begin
            r.pieces[s.pi[PSEL_W-1:0]] = {s.hi, acc[7:0]};
            r.pi = s.pi + 1'b1;
        end
        return r;
    endfunction

    logic [2:0]               r_phase,   n_phase;
    logic                     r_failed,  n_failed;
    t_piece [PIECE_COUNT-1:0] r_pieces,  n_pieces;
    logic [IDX_W-1:0]         r_pi,      n_pi;
    logic [IDX_W-1:0]         r_cp,      n_cp;
    logic                     r_cs,      n_cs;
    logic [PIECE_W-1:0]       r_hex_acc, n_hex_acc;
    logic [HCNT_W-1:0]        r_hex_cnt, n_hex_cnt;
    logic [DOT_W-1:0]         r_dot_acc, n_dot_acc;
    logic [DCNT_W-1:0]        r_dot_cnt, n_dot_cnt;
    logic [7:0]               r_dot_hi,  n_dot_hi;

    logic [CHAR_W-1:0]        w_char;
    logic                     w_take;

    assign w_char       = i_in.char_byte;
    assign w_take       = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid && i_in.last_byte;

    always_comb begin
        t_hex               hx;
        t_dot               ds;
        t_close             cl;
        logic [PIECE_W-1:0] aligned;
        logic [3:0]         dig;
        logic               dig_ok;
        logic               run_end;

        n_phase   = r_phase;
        n_failed  = r_failed;
        n_pieces  = r_pieces;
        n_pi      = r_pi;
        n_cp      = r_cp;
        n_cs      = r_cs;
        n_hex_acc = r_hex_acc;
        n_hex_cnt = r_hex_cnt;
        n_dot_acc = r_dot_acc;
        n_dot_cnt = r_dot_cnt;
        n_dot_hi  = r_dot_hi;
        hx        = hex_val(w_char);
        ds        = '0;
        cl        = '0;
        aligned   = '0;
        dig       = '0;
        dig_ok    = 1'b0;
        run_end   = 1'b0;

        if (r_phase != PH_DONE && w_char != CH_NUL) begin
            case (r_phase)
                PH_START, PH_PIECE, PH_AFTER_COLON: begin
                    if (r_phase == PH_START && w_char == CH_COLON) begin
                        n_phase = PH_LEAD;
                    end else if (r_pi >= IDX_W'(PIECE_COUNT)) begin
                        n_failed = 1'b1;
                        n_phase  = PH_DONE;
                    end else if (w_char == CH_COLON) begin
                        if (r_cs) begin
                            n_failed = 1'b1;
                            n_phase  = PH_DONE;
                        end else begin
                            n_pi    = r_pi + 1'b1;
                            n_cp    = r_pi + 1'b1;
                            n_cs    = 1'b1;
                            n_phase = PH_PIECE;
                        end
                    end else if (!hx.valid) begin
                        n_failed = 1'b1;
                        n_phase  = PH_DONE;
                    end else begin
                        n_hex_acc = {{(PIECE_W-4){1'b0}}, hx.value};
                        n_hex_cnt = HCNT_W'(1);
                        n_phase   = PH_HEX;
                    end
                end
                PH_LEAD: begin
                    if (w_char != CH_COLON) begin
                        n_failed = 1'b1;
                        n_phase  = PH_DONE;
                    end else begin
                        n_pi    = IDX_W'(1);
                        n_cp    = IDX_W'(1);
                        n_cs    = 1'b1;
                        n_phase = PH_PIECE;
                    end
                end
                PH_HEX: begin
                    if (hx.valid && r_hex_cnt < HCNT_W'(HEX_DIGITS)) begin
                        n_hex_acc = {r_hex_acc[PIECE_W-5:0], hx.value};
                        n_hex_cnt = r_hex_cnt + 1'b1;
                    end else if (w_char == CH_DOT) begin
                        if (r_pi > IDX_W'(PIECE_COUNT - 2)) begin
                            n_failed = 1'b1;
                            n_phase  = PH_DONE;
                        end else begin
                            // Reread the held hex digits as the first IPv4 number.
                            aligned   = r_hex_acc << {3'd4 - r_hex_cnt, 2'b00};
                            n_dot_acc = DOT_EMPTY;
                            n_dot_cnt = '0;
                            dig_ok    = 1'b1;
                            for (int i = 0; i < HEX_DIGITS; i++) begin
                                if (HCNT_W'(i) < r_hex_cnt) begin
                                    dig = aligned[PIECE_W-1-4*i -: 4];
                                    ds  = dot_step(n_dot_acc, dig);
                                    if (dig > 4'd9 || !ds.ok) begin
                                        dig_ok = 1'b0;
                                    end
                                    n_dot_acc = ds.acc;
                                end
                            end
                            if (!dig_ok) begin
                                n_failed = 1'b1;
                                n_phase  = PH_DONE;
                            end else begin
                                cl = dot_close({n_pieces, n_pi, n_dot_cnt, n_dot_hi},
                                               n_dot_acc);
                                {n_pieces, n_pi, n_dot_cnt, n_dot_hi} = cl;
                                n_dot_acc = DOT_EMPTY;
                                n_hex_cnt = '0;
                                n_phase   = PH_DOTTED;
                            end
                        end
                    end else if (w_char == CH_COLON) begin
                        n_pieces[r_pi[PSEL_W-1:0]] = r_hex_acc;
                        n_pi      = r_pi + 1'b1;
                        n_hex_cnt = '0;
                        n_phase   = PH_AFTER_COLON;
                    end else begin
                        n_failed = 1'b1;
                        n_phase  = PH_DONE;
                    end
                end
                PH_DOTTED: begin
                    if (w_char inside {[CH_0:CH_9]}) begin
                        ds = dot_step(r_dot_acc, 4'(w_char - CH_0));
                        if (!ds.ok) begin
                            n_failed = 1'b1;
                            n_phase  = PH_DONE;
                        end else begin
                            n_dot_acc = ds.acc;
                        end
                    end else if (w_char == CH_DOT && r_dot_acc != DOT_EMPTY) begin
                        cl = dot_close({n_pieces, n_pi, n_dot_cnt, n_dot_hi}, r_dot_acc);
                        {n_pieces, n_pi, n_dot_cnt, n_dot_hi} = cl;
                        if (n_dot_cnt >= DCNT_W'(DOT_GROUPS)) begin
                            n_failed = 1'b1;
                            n_phase  = PH_DONE;
                        end else begin
                            n_dot_acc = DOT_EMPTY;
                        end
                    end else begin
                        n_failed = 1'b1;
                        n_phase  = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // End of text: a zero byte, or the last byte if the address is still open.
        run_end = (n_phase != PH_DONE) && (w_char == CH_NUL || i_in.last_byte);
        if (run_end) begin
            case (n_phase)
                PH_START, PH_PIECE: begin
                    if (!n_cs && n_pi != IDX_W'(PIECE_COUNT)) begin
                        n_failed = 1'b1;
                    end
                    n_phase = PH_DONE;
                end
                PH_HEX: begin
                    n_pieces[n_pi[PSEL_W-1:0]] = n_hex_acc;
                    n_pi = n_pi + 1'b1;
                    if (!n_cs && n_pi != IDX_W'(PIECE_COUNT)) begin
                        n_failed = 1'b1;
                    end
                    n_phase = PH_DONE;
                end
                PH_DOTTED: begin
                    if (n_dot_acc == DOT_EMPTY) begin
                        n_failed = 1'b1;
                    end else begin
                        cl = dot_close({n_pieces, n_pi, n_dot_cnt, n_dot_hi}, n_dot_acc);
                        {n_pieces, n_pi, n_dot_cnt, n_dot_hi} = cl;
                        if (n_dot_cnt != DCNT_W'(DOT_GROUPS)) begin
                            n_failed = 1'b1;
                        end else if (!n_cs && n_pi != IDX_W'(PIECE_COUNT)) begin
                            n_failed = 1'b1;
                        end
                    end
                    n_phase = PH_DONE;
                end
                PH_DONE: begin
                end
                default: begin
                    n_failed = 1'b1;
                    n_phase  = PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        o_push_job               = '0;
        o_push_job.ok            = !n_failed;
        o_push_job.compress_seen = n_cs;
        o_push_job.piece_index   = n_pi;
        o_push_job.compress_pos  = n_cp;
        o_push_job.pieces        = n_pieces;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_in.last_byte)) begin
            r_phase   <= PH_START;
            r_failed  <= 1'b0;
            r_pieces  <= '0;
            r_pi      <= '0;
            r_cp      <= '0;
            r_cs      <= 1'b0;
            r_hex_acc <= '0;
            r_hex_cnt <= '0;
            r_dot_acc <= DOT_EMPTY;
            r_dot_cnt <= '0;
            r_dot_hi  <= '0;
        end else if (w_take) begin
            r_phase   <= n_phase;
            r_failed  <= n_failed;
            r_pieces  <= n_pieces;
            r_pi      <= n_pi;
            r_cp      <= n_cp;
            r_cs      <= n_cs;
            r_hex_acc <= n_hex_acc;
            r_hex_cnt <= n_hex_cnt;
            r_dot_acc <= n_dot_acc;
            r_dot_cnt <= n_dot_cnt;
            r_dot_hi  <= n_dot_hi;
        end
    end

    a_pi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pi <= IDX_W'(PIECE_COUNT))
        else $error("piece index beyond eight");

    a_cp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cs |-> (r_cp != '0 && r_cp <= r_pi))
        else $error("compression position outside parsed pieces");

    a_hex_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_cnt <= HCNT_W'(HEX_DIGITS))
        else $error("hex digit count overflow");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in.last_byte) |=> (r_phase == PH_START && r_pi == '0 && !r_failed))
        else $error("parser not cleared after last word");

endmodule

@@ rtl/ipv6ap_queue.sv @@
// Short job queue between the parser and the expansion stage.
// Uses ipv6ap_pkg for the job type; DEPTH must be 2 or more.
module ipv6ap_queue #(
    parameter int DEPTH = ipv6ap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  ipv6ap_pkg::t_job  i_push_job,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output ipv6ap_pkg::t_job  o_pop_job
);
    import ipv6ap_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push, w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

@@ rtl/ipv6ap_back.sv @@
// Expansion stage: moves the pieces after '::' to the end of the address and
// holds the result word in an output register. Uses ipv6ap_pkg and ipv6ap_out_if.
module ipv6ap_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  ipv6ap_pkg::t_job  i_job,
    ipv6ap_out_if.source      o_out
);
    import ipv6ap_pkg::*;

    t_piece [PIECE_COUNT-1:0] w_exp;
    logic [HALF_W-1:0]        w_high, w_low;
    logic                     w_load;

    logic                     r_valid;
    logic                     r_ok;
    logic [HALF_W-1:0]        r_high, r_low;

    // Slots below the pieces still unparsed are zero, so the expansion is a
    // plain shift of the tail by the number of missing pieces.
    always_comb begin
        logic [IDX_W-1:0] gap;
        logic [IDX_W-1:0] hi_start;
        logic [IDX_W-1:0] src;
        gap      = IDX_W'(PIECE_COUNT) - i_job.piece_index;
        hi_start = i_job.compress_pos + gap;
        src      = '0;
        for (int j = 0; j < PIECE_COUNT; j++) begin
            src = IDX_W'(j) - gap;
            if (!i_job.compress_seen || IDX_W'(j) < i_job.compress_pos) begin
                w_exp[j] = i_job.pieces[j];
            end else if (IDX_W'(j) >= hi_start) begin
                w_exp[j] = i_job.pieces[src[PSEL_W-1:0]];
            end else begin
                w_exp[j] = '0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < PIECE_COUNT / 2; k++) begin
            w_high[HALF_W-1-PIECE_W*k -: PIECE_W] = w_exp[k];
            w_low [HALF_W-1-PIECE_W*k -: PIECE_W] = w_exp[k + PIECE_COUNT/2];
        end
    end

    assign o_job_ready     = !r_valid || o_out.ready;
    assign w_load          = i_job_valid && o_job_ready;
    assign o_out.valid     = r_valid;
    assign o_out.parse_ok  = r_ok;
    assign o_out.addr_high = r_high;
    assign o_out.addr_low  = r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok   <= i_job.ok;
            r_high <= i_job.ok ? w_high : '0;
            r_low  <= i_job.ok ? w_low  : '0;
        end
    end

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_high == '0 && r_low == '0))
        else $error("failed result carries a nonzero address");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_valid)
        else $error("loaded job not offered");

    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_ok == $past(i_job.ok))
        else $error("status flag lost on load");

endmodule

@@ rtl/ipv6_address_parser_top.sv @@
// IPv6 address text parser, top level.
// Input channel i_in: one ASCII character per word (char_byte) with last_byte
// marking the final character of an address. Output channel o_out: one word per
// address, parse_ok plus the 128-bit address as addr_high (pieces 0..3, piece 0
// on top) and addr_low (pieces 4..7); a failed parse gives a zero address.
// A zero byte ends the address text early; later bytes up to the last are ignored.
// Throughput: one character per cycle in while i_in.ready is high; the expansion
// stage emits one result per cycle while o_out.ready is high, so addresses of
// any length stream without gaps.
// Path: the finished job enters the job queue with the last character and then
// passes into the output register.
// Stall: the output register holds a result until o_out.ready; finished jobs
// collect in the QUEUE_DEPTH-entry queue, and i_in.ready drops while it is full.
// Reset (synchronous, active low) clears the parser, empties the queue and drops
// o_out.valid; no clearing pass is needed.
module ipv6_address_parser_top #(
    parameter int QUEUE_DEPTH = ipv6ap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6ap_in_if.sink     i_in,
    ipv6ap_out_if.source  o_out
);
    import ipv6ap_pkg::*;

    logic  w_push_valid, w_push_ready;
    logic  w_pop_valid,  w_pop_ready;
    t_job  w_push_job,   w_pop_job;

    ipv6ap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    ipv6ap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    ipv6ap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job       (w_pop_job),
        .o_out       (o_out)
    );

endmodule
